@@ rtl/core/scdrv_pkg.sv @@
// ----------------------------------------------------------------------------
// scdrv_pkg
// Shared codes, command record and sequencer states for the shift register
// chain driver.
// ----------------------------------------------------------------------------
`default_nettype none

package scdrv_pkg;

    // Command codes on the action port.
    localparam logic [2:0] ACT_SET_PIN    = 3'd0;
    localparam logic [2:0] ACT_WRITE_PIN  = 3'd1;
    localparam logic [2:0] ACT_READ_PIN   = 3'd2;
    localparam logic [2:0] ACT_WRITE_BYTE = 3'd3;
    localparam logic [2:0] ACT_SET_ALL    = 3'd4;
    localparam logic [2:0] ACT_UPDATE     = 3'd5;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_SET_PIN,
        KIND_WRITE_PIN,
        KIND_READ_PIN,
        KIND_WRITE_BYTE,
        KIND_SET_ALL,
        KIND_UPDATE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] chip;
        logic [2:0] bit_sel;
        logic       level;
        logic [7:0] data;
        logic       in_range;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_SHIFT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/shift_register_chain_driver_core.sv @@
// ----------------------------------------------------------------------------
// shift_register_chain_driver_core
// Shadow-byte driver for a chain of serial-in, parallel-out shift registers.
//
// Commands enter on start/busy: a command is taken at a clock edge with
// start high and busy low. Busy rises only when the two-entry command queue
// is full. The chip count is written on cfg_valid/cfg_ready (always ready)
// and must be written only while the block is idle; it is clamped to the
// range 1 to MAX_CHIPS.
// Results leave on result_strobe, at most one word per cycle, and the receiver
// cannot stall them. With the back end idle, a taken command passes the
// queue, the idle and exec states and the output registers before a read
// reply shows; an update passes the load state as well before its first
// serial bit. An update emits chip_count*8 serial bits, farthest chip
// first and MSB first, with latch_after on the last one; for each chip the
// shifter loads the byte and then shifts its eight bits out. The back end
// pops the next command only in its idle state, so an update holds it until
// its last bit is out. Reset clears all shadow bytes, empties the queue and
// sets the count to one.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_register_chain_driver_core #(
    parameter int MAX_CHIPS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] action,
    input  wire logic [5:0] pin_index,
    input  wire logic [2:0] chip_index,
    input  wire logic [7:0] value,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data,
    output logic            result_strobe,
    output logic            is_read,
    output logic            serial_bit,
    output logic            latch_after,
    output logic            read_value
);

    logic [3:0]      chip_count_reg;
    logic [3:0]      chip_count_next;
    logic            queue_full;
    logic            queue_empty;
    logic            push;
    logic            pop;
    scdrv_pkg::cmd_t push_cmd;
    scdrv_pkg::cmd_t head_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        chip_count_next = chip_count_reg;
        if (cfg_valid)
        begin
            if (cfg_data == 4'd0)
            begin
                chip_count_next = 4'd1;
            end
            else if (cfg_data > 4'(MAX_CHIPS))
            begin
                chip_count_next = 4'(MAX_CHIPS);
            end
            else
            begin
                chip_count_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_count_reg <= 4'd1;
        end
        else
        begin
            chip_count_reg <= chip_count_next;
        end
    end

    scdrv_front u_front (
        .start      (start),
        .queue_full (queue_full),
        .action     (action),
        .pin_index  (pin_index),
        .chip_index (chip_index),
        .value      (value),
        .chip_count (chip_count_reg),
        .busy       (busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    scdrv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    scdrv_back #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .chip_count    (chip_count_reg),
        .queue_empty   (queue_empty),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .result_strobe (result_strobe),
        .is_read       (is_read),
        .serial_bit    (serial_bit),
        .latch_after   (latch_after),
        .read_value    (read_value)
    );

endmodule

`default_nettype wire

@@ rtl/core/scdrv_front.sv @@
// ----------------------------------------------------------------------------
// scdrv_front
// Accepts commands, checks chip ranges and turns each command into a queue
// entry; commands with no effect are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module scdrv_front (
    input  wire logic             start,
    input  wire logic             queue_full,
    input  wire logic [2:0]       action,
    input  wire logic [5:0]       pin_index,
    input  wire logic [2:0]       chip_index,
    input  wire logic [7:0]       value,
    input  wire logic [3:0]       chip_count,
    output logic                  busy,
    output logic                  push,
    output scdrv_pkg::cmd_t       cmd
);

    logic       accept;
    logic       pin_ok;
    logic       byte_ok;
    logic       keep;

    assign busy    = queue_full;
    assign accept  = start & ~queue_full;
    assign pin_ok  = {1'b0, pin_index[5:3]} < chip_count;
    assign byte_ok = {1'b0, chip_index} < chip_count;

    always_comb
    begin
        cmd          = '0;
        keep         = 1'b1;
        cmd.bit_sel  = pin_index[2:0];
        cmd.level    = (value != 8'd0);
        cmd.data     = value;
        cmd.chip     = pin_index[5:3];
        cmd.in_range = pin_ok;
        case (action)
            scdrv_pkg::ACT_SET_PIN:
            begin
                cmd.kind = scdrv_pkg::KIND_SET_PIN;
                keep     = pin_ok;
            end
            scdrv_pkg::ACT_WRITE_PIN:
            begin
                // Out of range still sends the update.
                cmd.kind = pin_ok ? scdrv_pkg::KIND_WRITE_PIN : scdrv_pkg::KIND_UPDATE;
            end
            scdrv_pkg::ACT_READ_PIN:
            begin
                cmd.kind = scdrv_pkg::KIND_READ_PIN;
            end
            scdrv_pkg::ACT_WRITE_BYTE:
            begin
                cmd.kind     = scdrv_pkg::KIND_WRITE_BYTE;
                cmd.chip     = chip_index;
                cmd.in_range = byte_ok;
                keep         = byte_ok;
            end
            scdrv_pkg::ACT_SET_ALL:
            begin
                cmd.kind = scdrv_pkg::KIND_SET_ALL;
            end
            scdrv_pkg::ACT_UPDATE:
            begin
                cmd.kind = scdrv_pkg::KIND_UPDATE;
            end
            default:
            begin
                cmd.kind = scdrv_pkg::KIND_UPDATE;
                keep     = 1'b0;
            end
        endcase
    end

    assign push = accept & keep;

endmodule

`default_nettype wire

@@ rtl/core/scdrv_queue.sv @@
// ----------------------------------------------------------------------------
// scdrv_queue
// Two-entry command queue that lets the front accept while the back shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module scdrv_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire scdrv_pkg::cmd_t  push_cmd,
    input  wire logic             pop,
    output scdrv_pkg::cmd_t       head_cmd,
    output logic                  empty,
    output logic                  full
);

    localparam int PW = (scdrv_pkg::QUEUE_DEPTH > 1) ? $clog2(scdrv_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(scdrv_pkg::QUEUE_DEPTH + 1);

    scdrv_pkg::cmd_t entry_reg [scdrv_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;
    logic            do_push;
    logic            do_pop;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CW'(scdrv_pkg::QUEUE_DEPTH));
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(scdrv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(scdrv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/scdrv_back.sv @@
// ----------------------------------------------------------------------------
// scdrv_back
// Holds the shadow bytes, applies queued commands and shifts the chain
// out one bit per cycle, with a byte load step before each chip.
// ----------------------------------------------------------------------------
`default_nettype none

module scdrv_back #(
    parameter int MAX_CHIPS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [3:0]       chip_count,
    input  wire logic             queue_empty,
    input  wire scdrv_pkg::cmd_t  head_cmd,
    output logic                  pop,
    output logic                  result_strobe,
    output logic                  is_read,
    output logic                  serial_bit,
    output logic                  latch_after,
    output logic                  read_value
);

    localparam int AW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

    scdrv_pkg::state_t state_reg;
    scdrv_pkg::state_t state_next;
    scdrv_pkg::cmd_t   cmd_reg;
    logic [7:0]        shadow_reg [MAX_CHIPS];
    logic [AW-1:0]     chip_ctr_reg;
    logic [AW-1:0]     chip_ctr_next;
    logic [2:0]        bit_ctr_reg;
    logic [2:0]        bit_ctr_next;
    logic [7:0]        shift_reg;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_byte;
    logic [AW-1:0]     cmd_addr;
    logic              needs_update;
    logic              strobe_next;
    logic              is_read_next;
    logic              serial_bit_next;
    logic              latch_next;
    logic              read_value_next;
    logic              strobe_reg;
    logic              is_read_reg;
    logic              serial_bit_reg;
    logic              latch_reg;
    logic              read_value_reg;

    assign cmd_addr = cmd_reg.chip[AW-1:0];
    assign rd_addr  = (state_reg == scdrv_pkg::ST_EXEC) ? cmd_addr : chip_ctr_reg;
    assign rd_byte  = shadow_reg[rd_addr];
    assign pop      = (state_reg == scdrv_pkg::ST_IDLE) & ~queue_empty;

    always_comb
    begin
        case (cmd_reg.kind)
            scdrv_pkg::KIND_WRITE_PIN,
            scdrv_pkg::KIND_WRITE_BYTE,
            scdrv_pkg::KIND_SET_ALL,
            scdrv_pkg::KIND_UPDATE:     needs_update = 1'b1;
            default:                    needs_update = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next    = state_reg;
        chip_ctr_next = chip_ctr_reg;
        bit_ctr_next  = bit_ctr_reg;
        case (state_reg)
            scdrv_pkg::ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = scdrv_pkg::ST_EXEC;
                end
            end
            scdrv_pkg::ST_EXEC:
            begin
                if (needs_update)
                begin
                    chip_ctr_next = AW'(chip_count - 4'd1);
                    state_next    = scdrv_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = scdrv_pkg::ST_IDLE;
                end
            end
            scdrv_pkg::ST_LOAD:
            begin
                bit_ctr_next = 3'd7;
                state_next   = scdrv_pkg::ST_SHIFT;
            end
            scdrv_pkg::ST_SHIFT:
            begin
                bit_ctr_next = bit_ctr_reg - 3'd1;
                if (bit_ctr_reg == 3'd0)
                begin
                    if (chip_ctr_reg == '0)
                    begin
                        state_next = scdrv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        chip_ctr_next = chip_ctr_reg - 1'b1;
                        state_next    = scdrv_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = scdrv_pkg::ST_IDLE;
            end
        endcase
    end

    // Result outputs.
    always_comb
    begin
        strobe_next     = 1'b0;
        is_read_next    = 1'b0;
        serial_bit_next = 1'b0;
        latch_next      = 1'b0;
        read_value_next = 1'b0;
        case (state_reg)
            scdrv_pkg::ST_EXEC:
            begin
                if (cmd_reg.kind == scdrv_pkg::KIND_READ_PIN)
                begin
                    strobe_next     = 1'b1;
                    is_read_next    = 1'b1;
                    read_value_next = cmd_reg.in_range & rd_byte[cmd_reg.bit_sel];
                end
            end
            scdrv_pkg::ST_SHIFT:
            begin
                strobe_next     = 1'b1;
                serial_bit_next = shift_reg[7];
                latch_next      = (bit_ctr_reg == 3'd0) && (chip_ctr_reg == '0);
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= scdrv_pkg::ST_IDLE;
            chip_ctr_reg <= '0;
            bit_ctr_reg  <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chip_ctr_reg <= chip_ctr_next;
            bit_ctr_reg  <= bit_ctr_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_read_reg    <= is_read_next;
        serial_bit_reg <= serial_bit_next;
        latch_reg      <= latch_next;
        read_value_reg <= read_value_next;
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (state_reg == scdrv_pkg::ST_LOAD)
        begin
            shift_reg <= rd_byte;
        end
        else if (state_reg == scdrv_pkg::ST_SHIFT)
        begin
            shift_reg <= {shift_reg[6:0], 1'b0};
        end
    end

    // Shadow store; the front only queues pin and byte writes that are in range.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHIPS; c++)
            begin
                shadow_reg[c] <= '0;
            end
        end
        else if (state_reg == scdrv_pkg::ST_EXEC)
        begin
            case (cmd_reg.kind)
                scdrv_pkg::KIND_SET_PIN,
                scdrv_pkg::KIND_WRITE_PIN:
                begin
                    shadow_reg[cmd_addr][cmd_reg.bit_sel] <= cmd_reg.level;
                end
                scdrv_pkg::KIND_WRITE_BYTE:
                begin
                    shadow_reg[cmd_addr] <= cmd_reg.data;
                end
                scdrv_pkg::KIND_SET_ALL:
                begin
                    for (int c = 0; c < MAX_CHIPS; c++)
                    begin
                        if (4'(c) < chip_count)
                        begin
                            shadow_reg[c] <= cmd_reg.data;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign is_read       = is_read_reg;
    assign serial_bit    = serial_bit_reg;
    assign latch_after   = latch_reg;
    assign read_value    = read_value_reg;

endmodule

`default_nettype wire

@@ tb/shift_register_chain_driver_core_test.sv @@
// ----------------------------------------------------------------------------
// shift_register_chain_driver_core_test
// Self-checking bench for the shift register chain driver. A short table of
// directed commands comes first. Random command streams follow at several
// chip counts and sender idle rates. Every result word is compared with a
// behavioral shadow byte model, or, for directed reads, with typed values.
// ----------------------------------------------------------------------------
module shift_register_chain_driver_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAIN_MAX = 8;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS = 66;
    localparam int NUM_PHASES = 6;

    typedef struct packed {
        logic is_read;
        logic serial_bit;
        logic latch_after;
        logic read_value;
    } chain_word_t;

    typedef struct {
        bit         cfg;
        logic [2:0] act;
        logic [5:0] pin;
        logic [2:0] chip;
        logic [7:0] val;
        bit         typed;
        logic       level;
    } directed_step_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] action = scdrv_pkg::ACT_SET_PIN;
    logic [5:0] pin_index = '0;
    logic [2:0] chip_index = '0;
    logic [7:0] value = '0;
    logic       cfg_valid = 1'b0;
    logic [3:0] cfg_data = '0;
    logic       busy;
    logic       cfg_ready;
    logic       result_strobe;
    logic       is_read;
    logic       serial_bit;
    logic       latch_after;
    logic       read_value;

    // Bench copy of the shadow bytes and the chip count.
    logic [7:0]  shadow_model [CHAIN_MAX];
    int unsigned chips_model;
    chain_word_t pending_words [$];
    int          faults = 0;

    shift_register_chain_driver_core #(
        .MAX_CHIPS(CHAIN_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .pin_index(pin_index),
        .chip_index(chip_index),
        .value(value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_strobe(result_strobe),
        .is_read(is_read),
        .serial_bit(serial_bit),
        .latch_after(latch_after),
        .read_value(read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("shift_register_chain_driver_core test failed");
        $finish;
    end

    // Queues the serial words of one update: farthest chip first, MSB first.
    function automatic void shift_out_chain();
        int total;
        int k;
        total = int'(chips_model) * 8;
        k = 0;
        for (int c = int'(chips_model) - 1; c >= 0; c--)
        begin
            for (int b = 7; b >= 0; b--)
            begin
                pending_words.push_back(chain_word_t'{1'b0, shadow_model[c][b],
                                                      (k == total - 1), 1'b0});
                k++;
            end
        end
    endfunction

    // Applies one accepted command to the model; returns 0 if it was ignored.
    function automatic bit apply_command(logic [2:0] act, logic [5:0] pin,
                                         logic [2:0] chip, logic [7:0] val);
        int unsigned pin_chip;
        bit          in_range;
        pin_chip = 32'(pin[5:3]);
        in_range = (pin_chip < chips_model);
        case (act)
            scdrv_pkg::ACT_SET_PIN:
            begin
                if (!in_range)
                    return 1'b0;
                shadow_model[pin_chip][pin[2:0]] = (val != 8'h00);
                return 1'b1;
            end
            scdrv_pkg::ACT_WRITE_PIN:
            begin
                if (in_range)
                    shadow_model[pin_chip][pin[2:0]] = (val != 8'h00);
                shift_out_chain();
                return 1'b1;
            end
            scdrv_pkg::ACT_READ_PIN:
            begin
                pending_words.push_back(chain_word_t'{1'b1, 1'b0, 1'b0,
                    in_range ? shadow_model[pin_chip][pin[2:0]] : 1'b0});
                return 1'b1;
            end
            scdrv_pkg::ACT_WRITE_BYTE:
            begin
                if (chip >= chips_model)
                    return 1'b0;
                shadow_model[chip] = val;
                shift_out_chain();
                return 1'b1;
            end
            scdrv_pkg::ACT_SET_ALL:
            begin
                for (int c = 0; c < int'(chips_model); c++)
                    shadow_model[c] = val;
                shift_out_chain();
                return 1'b1;
            end
            scdrv_pkg::ACT_UPDATE:
            begin
                shift_out_chain();
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_command(logic [2:0] act, logic [5:0] pin, logic [2:0] chip,
                                logic [7:0] val);
        start <= 1'b1;
        action <= act;
        pin_index <= pin;
        chip_index <= chip;
        value <= val;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic sender_gap(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < pct);
        end
    endtask

    // Commands that return nothing may still be in flight when the last
    // expected word arrives, so the settle time covers a full update.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_chip_count(logic [3:0] raw);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= raw;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (raw == 4'd0)
            chips_model = 1;
        else if (raw > CHAIN_MAX)
            chips_model = CHAIN_MAX;
        else
            chips_model = 32'(raw);
    endtask

    always @(posedge clk)
    begin
        chain_word_t seen;
        chain_word_t want;
        if (rst_n && result_strobe)
        begin
            seen = chain_word_t'{is_read, serial_bit, latch_after, read_value};
            if (pending_words.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected word: is_read=%b serial_bit=%b %s%b %s%b",
                             seen.is_read, seen.serial_bit, "latch_after=",
                             seen.latch_after, "read_value=", seen.read_value);
            end
            else
            begin
                want = pending_words.pop_front();
                if (seen !== want)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("word mismatch at %0t: expected %b %b %b %b, got %b %b %b %b",
                                 $realtime, want.is_read, want.serial_bit,
                                 want.latch_after, want.read_value, seen.is_read,
                                 seen.serial_bit, seen.latch_after, seen.read_value);
                end
            end
        end
    end

    initial
    begin
        directed_step_t steps [25];
        logic [3:0]     phase_count [NUM_PHASES];
        int             phase_idle [NUM_PHASES];
        int             done;
        logic [2:0]     act;
        logic [5:0]     pin;
        logic [2:0]     chip;
        logic [7:0]     val;

        foreach (shadow_model[i])
            shadow_model[i] = 8'h00;
        chips_model = 1;

        steps = '{
            '{1'b0, scdrv_pkg::ACT_READ_PIN,   6'd0,  3'd0, 8'h00, 1'b1, 1'b0},
            '{1'b0, scdrv_pkg::ACT_UPDATE,     6'd0,  3'd0, 8'h00, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_SET_PIN,    6'd7,  3'd0, 8'h01, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_SET_PIN,    6'd8,  3'd0, 8'h01, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_READ_PIN,   6'd7,  3'd0, 8'h00, 1'b1, 1'b1},
            '{1'b0, scdrv_pkg::ACT_READ_PIN,   6'd8,  3'd0, 8'h00, 1'b1, 1'b0},
            '{1'b0, scdrv_pkg::ACT_WRITE_PIN,  6'd0,  3'd0, 8'h80, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_WRITE_BYTE, 6'd0,  3'd1, 8'hAA, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_WRITE_BYTE, 6'd0,  3'd0, 8'h5A, 1'b0, 1'b0},
            '{1'b0, ACT_SPARE_6,               6'd63, 3'd7, 8'hFF, 1'b0, 1'b0},
            '{1'b0, ACT_SPARE_7,               6'd0,  3'd0, 8'h00, 1'b0, 1'b0},
            '{1'b1, scdrv_pkg::ACT_UPDATE,     6'd0,  3'd0, 8'h0F, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_SET_ALL,    6'd0,  3'd0, 8'hFF, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_READ_PIN,   6'd63, 3'd0, 8'h00, 1'b1, 1'b1},
            '{1'b0, scdrv_pkg::ACT_WRITE_PIN,  6'd63, 3'd0, 8'h00, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_WRITE_BYTE, 6'd0,  3'd7, 8'h00, 1'b0, 1'b0},
            '{1'b1, scdrv_pkg::ACT_UPDATE,     6'd0,  3'd0, 8'h00, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_SET_ALL,    6'd0,  3'd0, 8'h00, 1'b0, 1'b0},
            '{1'b1, scdrv_pkg::ACT_UPDATE,     6'd0,  3'd0, 8'h08, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_READ_PIN,   6'd15, 3'd0, 8'h00, 1'b1, 1'b1},
            '{1'b0, scdrv_pkg::ACT_UPDATE,     6'd0,  3'd0, 8'h00, 1'b0, 1'b0},
            '{1'b1, scdrv_pkg::ACT_UPDATE,     6'd0,  3'd0, 8'h03, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_WRITE_PIN,  6'd23, 3'd0, 8'h01, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_WRITE_PIN,  6'd40, 3'd0, 8'h01, 1'b0, 1'b0},
            '{1'b0, scdrv_pkg::ACT_READ_PIN,   6'd24, 3'd0, 8'h00, 1'b1, 1'b0}
        };

        phase_count[0] = 4'd1;
        phase_count[1] = 4'd15;
        phase_count[2] = 4'($urandom_range(2, 7));
        phase_count[3] = 4'd8;
        phase_count[4] = 4'($urandom_range(0, 15));
        phase_count[5] = 4'd0;
        phase_idle = '{0, 83, 37, 0, 83, 37};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].cfg)
                write_chip_count(steps[i].val[3:0]);
            else
            begin
                send_command(steps[i].act, steps[i].pin, steps[i].chip, steps[i].val);
                if (steps[i].typed)
                    pending_words.push_back(chain_word_t'{1'b1, 1'b0, 1'b0,
                                                          steps[i].level});
                else
                    void'(apply_command(steps[i].act, steps[i].pin, steps[i].chip,
                                        steps[i].val));
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_chip_count(phase_count[p]);
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 4)
                    act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
                else
                    act = 3'($urandom_range(int'(scdrv_pkg::ACT_SET_PIN),
                                            int'(scdrv_pkg::ACT_UPDATE)));
                // At least half of the pins and chips fall inside the chain in use.
                pin = $urandom_range(0, 1) ? 6'($urandom_range(0, chips_model * 8 - 1))
                                           : 6'($urandom);
                chip = $urandom_range(0, 1) ? 3'($urandom_range(0, chips_model - 1))
                                            : 3'($urandom);
                case ($urandom_range(0, 7))
                    0: val = 8'h00;
                    1: val = 8'hFF;
                    default: val = 8'($urandom);
                endcase
                send_command(act, pin, chip, val);
                void'(apply_command(act, pin, chip, val));
                done++;
                if ((p == 1 && done == PHASE_ITEMS / 2) || $urandom_range(0, 59) == 0)
                    drain_results();
                else
                    sender_gap(phase_idle[p]);
            end
        end

        drain_results();
        if (faults == 0 && pending_words.size() == 0)
            $display("shift_register_chain_driver_core test passed");
        else
            $display("shift_register_chain_driver_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/scdrv_pkg.sv
rtl/core/scdrv_front.sv
rtl/core/scdrv_queue.sv
rtl/core/scdrv_back.sv
rtl/core/shift_register_chain_driver_core.sv
tb/shift_register_chain_driver_core_test.sv
